// ----- rtl/mode_keyed_job_priority_queue_defines.svh -----
// Assertion macros used by the queue top-level RTL.
`ifndef MODE_KEYED_JOB_PRIORITY_QUEUE_DEFINES_SVH
`define MODE_KEYED_JOB_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define MKJPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MKJPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MKJPQ_ASSERT(lbl, prop, msg)
`define MKJPQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/mkjpq_pkg.sv -----
package mkjpq_pkg;

  localparam int DEFAULT_CAPACITY = 32;

  localparam int PID_W   = 10;
  localparam int PRIO_W  = 8;
  localparam int SIZE_W  = 16;
  localparam int KEY_HI_W = 16;
  localparam int KEY_W   = KEY_HI_W + PID_W;
  localparam int MODE_W  = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 6;

  localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PRIO = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIZE = 2'd2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // candidate passed down the cell chain during a head scan
  typedef struct packed {
    logic             found;
    logic             free_found;
    logic [KEY_W-1:0] key;
  } cand_t;

  // store command broadcast to all cells
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [PID_W-1:0]  pid;
    logic [PRIO_W-1:0] prio;
    logic [SIZE_W-1:0] size;
  } cmd_t;

endpackage

// ----- rtl/mkjpq_cell.sv -----
module mkjpq_cell #(
  parameter int CAPACITY = 32,
  parameter int INDEX    = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mkjpq_pkg::MODE_W-1:0] mode,
  input  mkjpq_pkg::cmd_t             cmd,
  input  logic [$clog2(CAPACITY)-1:0] cmd_slot,
  input  mkjpq_pkg::cand_t            cand_in,
  input  logic [$clog2(CAPACITY)-1:0] idx_in,
  input  logic [$clog2(CAPACITY)-1:0] free_in,
  output mkjpq_pkg::cand_t            cand_out,
  output logic [$clog2(CAPACITY)-1:0] idx_out,
  output logic [$clog2(CAPACITY)-1:0] free_out
);
  import mkjpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic              valid;
  logic [PID_W-1:0]  pid;
  logic [PRIO_W-1:0] prio;
  logic [SIZE_W-1:0] size;

  logic [KEY_HI_W-1:0] key_hi;
  logic [KEY_W-1:0]    own_key;
  logic                take;
  logic                hit;

  assign hit = (cmd_slot == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.ins && hit) begin
      valid <= 1'b1;
    end else if (cmd.del && hit) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins && hit) begin
      pid  <= cmd.pid;
      prio <= cmd.prio;
      size <= cmd.size;
    end
  end

  always_comb begin
    case (mode)
      MODE_PRIO: key_hi = KEY_HI_W'(prio);
      MODE_SIZE: key_hi = size;
      default:   key_hi = '0;
    endcase
  end

  assign own_key = {key_hi, pid};
  // strict compare keeps the lower slot on equal keys
  assign take = valid && (!cand_in.found || (own_key < cand_in.key));

  always_ff @(posedge clk) begin
    cand_out.found      <= cand_in.found | valid;
    cand_out.key        <= take ? own_key : cand_in.key;
    idx_out             <= take ? MY_IDX : idx_in;
    cand_out.free_found <= cand_in.free_found | !valid;
    free_out            <= cand_in.free_found ? free_in : MY_IDX;
  end

endmodule

// ----- rtl/mode_keyed_job_priority_queue.sv -----
// Channel  Handshake          Payload
// in       in_valid/in_stall  action, process_id, priority_req, program_size
// out      out_valid/out_stall served_pid, served_valid, head_pid, head_valid,
//                             entry_count, status
// cfg      cfg_valid/cfg_ready cfg_data (sched_mode)
//
// An insert or remove that changes the store has its result after a head search:
// the search walks the cell chain one cell per cycle. A refused item skips the
// search and goes straight to the result state. The next item is taken once a
// result is issued, or after the search that follows a mode write, which gives
// no result. Reset (rst, synchronous) empties the queue and sets FIFO mode. A
// stalled result waits in the output register.
`include "mode_keyed_job_priority_queue_defines.svh"

module mode_keyed_job_priority_queue #(
  parameter int CAPACITY = mkjpq_pkg::DEFAULT_CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [mkjpq_pkg::PID_W-1:0]   process_id,
  input  logic [mkjpq_pkg::PRIO_W-1:0]  priority_req,
  input  logic [mkjpq_pkg::SIZE_W-1:0]  program_size,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mkjpq_pkg::PID_W-1:0]   served_pid,
  output logic                          served_valid,
  output logic [mkjpq_pkg::PID_W-1:0]   head_pid,
  output logic                          head_valid,
  output logic [mkjpq_pkg::COUNT_W-1:0] entry_count,
  output logic [mkjpq_pkg::STAT_W-1:0]  status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mkjpq_pkg::MODE_W-1:0]  cfg_data
);
  import mkjpq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state;
  logic [MODE_W-1:0] mode;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  scan_cnt;
  logic              want_out;
  logic              head_ok;
  logic [IDX_W-1:0]  head_slot;
  logic [PID_W-1:0]  head_id;
  logic [IDX_W-1:0]  free_slot;

  logic [PID_W-1:0]  res_pid;
  logic              res_served;
  logic [STAT_W-1:0] res_status;

  cand_t            cand [CAPACITY+1];
  logic [IDX_W-1:0] idx_c [CAPACITY+1];
  logic [IDX_W-1:0] free_c [CAPACITY+1];

  cmd_t             cmd;
  logic [IDX_W-1:0] cmd_slot;
  logic             in_xfer;
  logic             cfg_xfer;
  logic             ins_ok;
  logic             del_ok;
  logic             scan_done;
  logic             out_free;

  assign in_stall  = (state != ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_xfer  = cfg_valid && cfg_ready;

  assign ins_ok = (action == ACT_INSERT) && (count != CAP_CNT);
  assign del_ok = (action == ACT_REMOVE) && head_ok;

  assign cmd.ins  = in_xfer && ins_ok;
  assign cmd.del  = in_xfer && del_ok;
  assign cmd.pid  = process_id;
  assign cmd.prio = priority_req;
  assign cmd.size = program_size;
  assign cmd_slot = (action == ACT_INSERT) ? free_slot : head_slot;

  assign cand[0]   = '0;
  assign idx_c[0]  = '0;
  assign free_c[0] = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mkjpq_cell #(
      .CAPACITY(CAPACITY),
      .INDEX   (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .mode    (mode),
      .cmd     (cmd),
      .cmd_slot(cmd_slot),
      .cand_in (cand[i]),
      .idx_in  (idx_c[i]),
      .free_in (free_c[i]),
      .cand_out(cand[i+1]),
      .idx_out (idx_c[i+1]),
      .free_out(free_c[i+1])
    );
  end

  assign scan_done = (state == ST_SCAN) && (scan_cnt == CAP_CNT);
  assign out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mode      <= MODE_FIFO;
      count     <= '0;
      scan_cnt  <= '0;
      want_out  <= 1'b0;
      head_ok   <= 1'b0;
      free_slot <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          scan_cnt <= '0;
          if (cfg_xfer) begin
            mode     <= cfg_data;
            want_out <= 1'b0;
            state    <= ST_SCAN;
          end else if (in_xfer) begin
            want_out <= 1'b1;
            if (ins_ok) begin
              count <= count + 1'b1;
              state <= ST_SCAN;
            end else if (del_ok) begin
              count <= count - 1'b1;
              state <= ST_SCAN;
            end else begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_done) begin
            head_ok   <= cand[CAPACITY].found;
            free_slot <= free_c[CAPACITY];
            state     <= want_out ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_served <= del_ok;
      res_pid    <= del_ok ? head_id : '0;
      if (action == ACT_INSERT) begin
        res_status <= ins_ok ? STAT_OK : STAT_FULL;
      end else begin
        res_status <= del_ok ? STAT_OK : STAT_EMPTY;
      end
    end
    if (scan_done) begin
      head_slot <= idx_c[CAPACITY];
      head_id   <= cand[CAPACITY].key[PID_W-1:0];
    end
    if (state == ST_EMIT && out_free) begin
      served_pid   <= res_pid;
      served_valid <= res_served;
      head_pid     <= head_ok ? head_id : '0;
      head_valid   <= head_ok;
      entry_count  <= COUNT_W'(count);
      status       <= res_status;
    end
  end

  `MKJPQ_ASSERT(a_count_bound, count <= CAP_CNT, "entry count above capacity")
  `MKJPQ_ASSERT(a_accept_leaves_idle, in_xfer |=> (state != ST_IDLE), "item taken but idle")
  `MKJPQ_ASSERT(a_full_only_at_cap,
                (state == ST_EMIT && res_status == STAT_FULL) |-> (count == CAP_CNT),
                "full status below capacity")
  `MKJPQ_ASSERT(a_scan_matches_count,
                scan_done |-> (cand[CAPACITY].found == (count != '0)),
                "head search disagrees with count")

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
  import mkjpq_pkg::*;

  localparam int DEPTH = DEFAULT_CAPACITY;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int IDLE_PCT = 23;
  localparam int SETTLE = DEPTH + 8;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic [PID_W-1:0]   served_pid;
    logic               served_valid;
    logic [PID_W-1:0]   head_pid;
    logic               head_valid;
    logic [COUNT_W-1:0] entry_count;
    logic [STAT_W-1:0]  status;
  } job_result_t;

  class job_board;
    logic [PID_W-1:0]  pid_at[DEPTH];
    logic [PRIO_W-1:0] prio_at[DEPTH];
    logic [SIZE_W-1:0] size_at[DEPTH];
    bit                used[DEPTH];
    int unsigned       held;
    logic [MODE_W-1:0] mode;
    job_result_t       waiting[$];
    int                errors;

    function new();
      for (int s = 0; s < DEPTH; s++) begin
        used[s] = 1'b0;
        pid_at[s] = '0;
        prio_at[s] = '0;
        size_at[s] = '0;
      end
      held = 0;
      mode = MODE_FIFO;
      errors = 0;
    endfunction

    function void set_mode(logic [MODE_W-1:0] m);
      mode = m;
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function logic [KEY_W-1:0] key_at(int s);
      case (mode)
        MODE_PRIO: key_at = {{(KEY_HI_W-PRIO_W){1'b0}}, prio_at[s], pid_at[s]};
        MODE_SIZE: key_at = {size_at[s], pid_at[s]};
        default:   key_at = {{KEY_HI_W{1'b0}}, pid_at[s]};
      endcase
    endfunction

    function int head_slot();
      int best;
      logic [KEY_W-1:0] best_key;
      best = DEPTH;
      best_key = '0;
      for (int s = 0; s < DEPTH; s++) begin
        if (used[s] && (best == DEPTH || key_at(s) < best_key)) begin
          best = s;
          best_key = key_at(s);
        end
      end
      return best;
    endfunction

    function void note_input(logic act, logic [PID_W-1:0] pid, logic [PRIO_W-1:0] prio,
                             logic [SIZE_W-1:0] size);
      job_result_t r;
      int slot;
      r = '0;
      r.status = STAT_OK;
      if (act == ACT_INSERT) begin
        slot = DEPTH;
        for (int s = DEPTH - 1; s >= 0; s--)
          if (!used[s]) slot = s;
        if (slot == DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          pid_at[slot] = pid;
          prio_at[slot] = prio;
          size_at[slot] = size;
          used[slot] = 1'b1;
          held++;
        end
      end else begin
        slot = head_slot();
        if (slot == DEPTH) begin
          r.status = STAT_EMPTY;
        end else begin
          r.served_pid = pid_at[slot];
          r.served_valid = 1'b1;
          used[slot] = 1'b0;
          held--;
        end
      end
      slot = head_slot();
      if (slot != DEPTH) begin
        r.head_pid = pid_at[slot];
        r.head_valid = 1'b1;
      end
      r.entry_count = held[COUNT_W-1:0];
      waiting.push_back(r);
    endfunction

    function void check_result(job_result_t got);
      job_result_t want;
      if (waiting.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: served %0d/%0b head %0d/%0b count %0d status %0d",
                   got.served_pid, got.served_valid, got.head_pid, got.head_valid,
                   got.entry_count, got.status);
        return;
      end
      want = waiting.pop_front();
      if (got.served_pid !== want.served_pid || got.served_valid !== want.served_valid ||
          got.head_pid !== want.head_pid || got.head_valid !== want.head_valid ||
          got.entry_count !== want.entry_count || got.status !== want.status) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: expected served %0d/%0b head %0d/%0b count %0d status %0d",
                   want.served_pid, want.served_valid, want.head_pid, want.head_valid,
                   want.entry_count, want.status);
          $display("          actual   served %0d/%0b head %0d/%0b count %0d status %0d",
                   got.served_pid, got.served_valid, got.head_pid, got.head_valid,
                   got.entry_count, got.status);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = ACT_INSERT;
  logic [PID_W-1:0] process_id = '0;
  logic [PRIO_W-1:0] priority_req = '0;
  logic [SIZE_W-1:0] program_size = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PID_W-1:0] served_pid;
  logic served_valid;
  logic [PID_W-1:0] head_pid;
  logic head_valid;
  logic [COUNT_W-1:0] entry_count;
  logic [STAT_W-1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MODE_W-1:0] cfg_data = MODE_FIFO;

  job_board board = new();
  bit calm = 1'b0;
  int sent = 0;

  mode_keyed_job_priority_queue DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .process_id(process_id),
    .priority_req(priority_req),
    .program_size(program_size),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .served_pid(served_pid),
    .served_valid(served_valid),
    .head_pid(head_pid),
    .head_valid(head_valid),
    .entry_count(entry_count),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    job_result_t got;
    got.served_pid = served_pid;
    got.served_valid = served_valid;
    got.head_pid = head_pid;
    got.head_valid = head_valid;
    got.entry_count = entry_count;
    got.status = status;
    if (!rst && out_valid && !out_stall) board.check_result(got);
    out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_job(logic act, logic [PID_W-1:0] pid, logic [PRIO_W-1:0] prio,
                          logic [SIZE_W-1:0] size);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    process_id <= pid;
    priority_req <= prio;
    program_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(act, pid, prio, size);
    sent++;
  endtask

  task automatic send_random(int insert_pct);
    logic act;
    logic [PID_W-1:0] pid;
    logic [PRIO_W-1:0] prio;
    logic [SIZE_W-1:0] size;
    act = ($urandom_range(99) < insert_pct) ? ACT_INSERT : ACT_REMOVE;
    if ($urandom_range(1)) begin
      pid = PID_W'($urandom_range(7));
      prio = PRIO_W'($urandom_range(3));
      size = SIZE_W'($urandom_range(3));
    end else begin
      pid = PID_W'($urandom);
      prio = PRIO_W'($urandom);
      size = SIZE_W'($urandom);
    end
    send_job(act, pid, prio, size);
  endtask

  task automatic write_mode(logic [MODE_W-1:0] m);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_mode(m);
  endtask

  initial begin
    int phase;
    int len;
    int ins_pct;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty, extremes, duplicates, reorder on mode change
    send_job(ACT_REMOVE, '1, '1, '1);
    send_job(ACT_INSERT, 10'd1023, 8'd255, 16'd65535);
    send_job(ACT_INSERT, 10'd0, 8'd0, 16'd0);
    send_job(ACT_INSERT, 10'd512, 8'd255, 16'd0);
    send_job(ACT_INSERT, 10'd512, 8'd0, 16'd65535);
    send_job(ACT_REMOVE, 10'd0, 8'd0, 16'd0);
    write_mode(MODE_PRIO);
    send_job(ACT_INSERT, 10'd7, 8'd0, 16'd100);
    send_job(ACT_INSERT, 10'd7, 8'd0, 16'd100);
    send_job(ACT_REMOVE, 10'h155, 8'hAA, 16'h5555);
    send_job(ACT_REMOVE, 10'h2AA, 8'h55, 16'hAAAA);
    write_mode(MODE_SIZE);
    send_job(ACT_INSERT, 10'd300, 8'd1, 16'd0);
    send_job(ACT_REMOVE, 10'd0, 8'd0, 16'd0);
    send_job(ACT_REMOVE, 10'd0, 8'd0, 16'd0);
    write_mode(MODE_SPARE);
    send_job(ACT_INSERT, 10'd2, 8'd9, 16'd9);
    send_job(ACT_REMOVE, 10'd0, 8'd0, 16'd0);
    send_job(ACT_REMOVE, 10'd0, 8'd0, 16'd0);
    send_job(ACT_REMOVE, 10'd0, 8'd0, 16'd0);
    send_job(ACT_REMOVE, 10'd0, 8'd0, 16'd0);

    phase = 0;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_mode(phase % 4 == 0 ? MODE_FIFO : MODE_W'($urandom_range(3)));
      case (phase % 3)
        0: ins_pct = 85;
        1: ins_pct = 50;
        default: ins_pct = 20;
      endcase
      calm = (phase == 4);
      len = $urandom_range(60, 120);
      repeat (len) send_random(ins_pct);
      phase++;
    end
    calm = 1'b0;
    write_mode(MODE_SPARE);
    repeat (40) send_random(60);

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mkjpq_pkg.sv
rtl/mkjpq_cell.sv
rtl/mode_keyed_job_priority_queue.sv
tb/sv/testbench.sv
